[sv/mi3_pkg.sv]
`default_nettype none

package mi3_pkg;

  localparam int unsigned EW    = 32;
  localparam int unsigned NEL   = 9;
  localparam int unsigned CW    = 65;
  localparam int unsigned CMW   = 64;
  localparam int unsigned DW    = 97;
  localparam int unsigned DMW   = 96;
  localparam int unsigned QW    = 33;
  localparam int unsigned RW    = DMW + QW + 1;
  localparam int unsigned QD    = 2;
  localparam int unsigned FSTG  = 7;

  localparam logic [QW:0]   POS_LIMIT = (QW + 1)'(64'h7FFF_FFFF);
  localparam logic [QW:0]   NEG_LIMIT = (QW + 1)'(64'h8000_0000);
  localparam logic [EW-1:0] POS_SAT   = 32'h7FFF_FFFF;
  localparam logic [EW-1:0] NEG_SAT   = 32'h8000_0000;

  typedef struct packed {
    logic signed [EW-1:0] m_r0c0;
    logic signed [EW-1:0] m_r0c1;
    logic signed [EW-1:0] m_r0c2;
    logic signed [EW-1:0] m_r1c0;
    logic signed [EW-1:0] m_r1c1;
    logic signed [EW-1:0] m_r1c2;
    logic signed [EW-1:0] m_r2c0;
    logic signed [EW-1:0] m_r2c1;
    logic signed [EW-1:0] m_r2c2;
  } in_t;

  typedef struct packed {
    logic signed [EW-1:0] inv_r0c0;
    logic signed [EW-1:0] inv_r0c1;
    logic signed [EW-1:0] inv_r0c2;
    logic signed [EW-1:0] inv_r1c0;
    logic signed [EW-1:0] inv_r1c1;
    logic signed [EW-1:0] inv_r1c2;
    logic signed [EW-1:0] inv_r2c0;
    logic signed [EW-1:0] inv_r2c1;
    logic signed [EW-1:0] inv_r2c2;
    logic                 singular;
  } out_t;

  typedef struct packed {
    logic                      singular;
    logic                      det_neg;
    logic [DMW-1:0]            det_mag;
    logic [NEL-1:0]            cof_neg;
    logic [NEL-1:0][CMW-1:0]   cof_mag;
  } job_t;

endpackage

`default_nettype wire

[sv/matrix_inverse_3x3.sv]
`default_nettype none

// Inverts one 3x3 Q16.16 matrix per beat by adjugate over determinant, with every
// sum and product exact and a single rounding (to nearest, ties away from zero) in
// the division; results saturate to the 32-bit range, and a zero determinant gives
// singular set with all nine elements zero. One matrix is taken every clock cycle
// unless in_stall_o is raised: seven front stages form the cofactors and the
// determinant on 32-bit multipliers, a two-entry queue follows, and nine
// pipelined long dividers retire one quotient bit per stage over 33 stages.
module matrix_inverse_3x3 #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire mi3_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output mi3_pkg::out_t     out_data_o
);
  import mi3_pkg::*;

  logic push;
  logic q_ready;
  logic pop;
  logic q_empty;
  job_t push_data;
  job_t pop_data;

  mi3_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_ready_i   (q_ready),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mi3_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_data)
  );

  mi3_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[sv/mi3_front.sv]
`default_nettype none

module mi3_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire mi3_pkg::in_t in_data_i,
  input  wire logic         q_ready_i,
  output logic              push_o,
  output mi3_pkg::job_t     push_data_o
);
  import mi3_pkg::*;

  logic                 en;
  logic [FSTG:1]        v_q;
  logic signed [EW-1:0] m_in  [NEL];
  logic signed [EW-1:0] m_q   [NEL];
  logic signed [63:0]   p_q   [2*NEL];
  logic signed [EW-1:0] r0a_q [3];
  logic signed [EW-1:0] r0b_q [3];
  logic signed [CW-1:0] cof_q [NEL];
  logic signed [CW-1:0] cof4_q [NEL];
  logic signed [CW-1:0] cof5_q [NEL];
  logic signed [CW-1:0] cof6_q [NEL];
  logic signed [CW-1:0] ph_q  [3];
  logic signed [CW-1:0] pl_q  [3];
  logic signed [DW-1:0] t_q   [3];
  logic signed [DW-1:0] det_q;
  logic signed [CW-1:0] cabs  [NEL];
  logic signed [DW-1:0] dabs;
  job_t                 job_d;
  job_t                 job_q;

  assign en          = !(v_q[FSTG] && !q_ready_i);
  assign in_stall_o  = !en;
  assign push_o      = v_q[FSTG] && en;
  assign push_data_o = job_q;

  always_comb begin
    m_in[0] = in_data_i.m_r0c0;
    m_in[1] = in_data_i.m_r0c1;
    m_in[2] = in_data_i.m_r0c2;
    m_in[3] = in_data_i.m_r1c0;
    m_in[4] = in_data_i.m_r1c1;
    m_in[5] = in_data_i.m_r1c2;
    m_in[6] = in_data_i.m_r2c0;
    m_in[7] = in_data_i.m_r2c1;
    m_in[8] = in_data_i.m_r2c2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[FSTG-1:1], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NEL; k++) begin
        m_q[k] <= m_in[k];
      end
    end
  end

  // Each adjugate entry is a 2x2 cofactor of the transpose taken cyclically.
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      localparam int J1 = (j + 1) % 3;
      localparam int J2 = (j + 2) % 3;
      localparam int K  = i * 3 + j;
      always_ff @(posedge clk_i) begin
        if (en) begin
          p_q[2*K]   <= m_q[J1*3+I1] * m_q[J2*3+I2];
          p_q[2*K+1] <= m_q[J2*3+I1] * m_q[J1*3+I2];
          cof_q[K]   <= CW'(p_q[2*K]) - CW'(p_q[2*K+1]);
        end
      end
    end
  end

  // The determinant expands along row 0 with the first adjugate column.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        r0a_q[j] <= m_q[j];
        r0b_q[j] <= r0a_q[j];
        pl_q[j]  <= r0b_q[j] * $signed({1'b0, cof_q[j*3][31:0]});
        ph_q[j]  <= r0b_q[j] * $signed(cof_q[j*3][CW-1:32]);
        t_q[j]   <= (DW'(ph_q[j]) <<< 32) + DW'(pl_q[j]);
      end
      for (int k = 0; k < NEL; k++) begin
        cof4_q[k] <= cof_q[k];
        cof5_q[k] <= cof4_q[k];
        cof6_q[k] <= cof5_q[k];
      end
      det_q <= t_q[0] + t_q[1] + t_q[2];
      job_q <= job_d;
    end
  end

  always_comb begin
    dabs          = det_q[DW-1] ? -det_q : det_q;
    job_d.singular = (det_q == '0);
    job_d.det_neg  = det_q[DW-1];
    job_d.det_mag  = dabs[DMW-1:0];
    for (int k = 0; k < NEL; k++) begin
      cabs[k]          = cof6_q[k][CW-1] ? -cof6_q[k] : cof6_q[k];
      job_d.cof_neg[k] = cof6_q[k][CW-1];
      job_d.cof_mag[k] = cabs[k][CMW-1:0];
    end
  end

endmodule

`default_nettype wire

[sv/mi3_queue.sv]
`default_nettype none

module mi3_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire mi3_pkg::job_t push_data_i,
  output logic               ready_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output mi3_pkg::job_t      pop_data_o
);
  import mi3_pkg::*;

  localparam int unsigned AW = $clog2(QD);

  job_t              mem_q [QD];
  logic [AW-1:0]     wr_q;
  logic [AW-1:0]     rd_q;
  logic [AW:0]       cnt_q;

  assign empty_o    = (cnt_q == '0);
  assign ready_o    = (cnt_q != (AW + 1)'(QD)) || pop_i;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(QD - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(QD - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[sv/mi3_back.sv]
`default_nettype none

module mi3_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_empty_i,
  input  wire mi3_pkg::job_t q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output mi3_pkg::out_t      out_data_o
);
  import mi3_pkg::*;

  logic               en;
  logic [QW:0]        sv_q;
  logic [DMW-1:0]     ud_q [QW+1];
  logic               sg_q [QW+1];
  logic [RW-1:0]      r_q  [QW+1][NEL];
  logic [QW-1:0]      qb_q [QW+1][NEL];
  logic               ng_q [QW+1][NEL];
  logic               of_q [QW+1][NEL];
  logic [RW-1:0]      un   [NEL];
  logic [RW-1:0]      udw;
  logic [QW:0]        qr   [NEL];
  logic [EW-1:0]      res  [NEL];
  logic               ov_q;
  out_t               out_q;
  out_t               out_d;

  assign en          = !(ov_q && out_stall_i);
  assign pop_o       = en && !q_empty_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
      ov_q <= 1'b0;
    end else if (en) begin
      sv_q <= {sv_q[QW-1:0], !q_empty_i};
      ov_q <= sv_q[QW];
    end
  end

  // A quotient of 2^33 or more saturates either way, so 33 bits are developed.
  always_comb begin
    udw = RW'(q_data_i.det_mag);
    for (int l = 0; l < NEL; l++) begin
      un[l] = RW'(q_data_i.cof_mag[l]) << (2 * FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ud_q[0] <= q_data_i.det_mag;
      sg_q[0] <= q_data_i.singular;
      for (int l = 0; l < NEL; l++) begin
        r_q[0][l]  <= un[l];
        qb_q[0][l] <= '0;
        ng_q[0][l] <= q_data_i.cof_neg[l] ^ q_data_i.det_neg;
        of_q[0][l] <= (un[l] >= (udw << QW));
      end
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    localparam int unsigned BIT = QW - s;
    for (genvar l = 0; l < NEL; l++) begin : g_lane
      logic [RW-1:0] dsh;
      logic          take;
      assign dsh  = RW'(ud_q[s-1]) << BIT;
      assign take = (r_q[s-1][l] >= dsh);
      always_ff @(posedge clk_i) begin
        if (en) begin
          r_q[s][l]  <= take ? r_q[s-1][l] - dsh : r_q[s-1][l];
          qb_q[s][l] <= qb_q[s-1][l] | (QW'(take) << BIT);
          ng_q[s][l] <= ng_q[s-1][l];
          of_q[s][l] <= of_q[s-1][l];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        ud_q[s] <= ud_q[s-1];
        sg_q[s] <= sg_q[s-1];
      end
    end
  end

  // Round to nearest with ties away from zero, then saturate.
  always_comb begin
    for (int l = 0; l < NEL; l++) begin
      qr[l] = {1'b0, qb_q[QW][l]} +
              (QW + 1)'((r_q[QW][l] << 1) >= RW'(ud_q[QW]));
      if (sg_q[QW]) begin
        res[l] = '0;
      end else if (!ng_q[QW][l]) begin
        res[l] = (of_q[QW][l] || qr[l] > POS_LIMIT) ? POS_SAT : qr[l][EW-1:0];
      end else begin
        res[l] = (of_q[QW][l] || qr[l] > NEG_LIMIT) ? NEG_SAT : -qr[l][EW-1:0];
      end
    end
    out_d.inv_r0c0 = res[0];
    out_d.inv_r0c1 = res[1];
    out_d.inv_r0c2 = res[2];
    out_d.inv_r1c0 = res[3];
    out_d.inv_r1c1 = res[4];
    out_d.inv_r1c2 = res[5];
    out_d.inv_r2c0 = res[6];
    out_d.inv_r2c1 = res[7];
    out_d.inv_r2c2 = res[8];
    out_d.singular = sg_q[QW];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

[sv/mi3_checker.sv]
`default_nettype none

module mi3_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire mi3_pkg::out_t out_data_o,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i
);
  import mi3_pkg::*;

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_singular_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |->
      out_data_o.inv_r0c0 == '0 && out_data_o.inv_r0c1 == '0 &&
      out_data_o.inv_r0c2 == '0 && out_data_o.inv_r1c0 == '0 &&
      out_data_o.inv_r1c1 == '0 && out_data_o.inv_r1c2 == '0 &&
      out_data_o.inv_r2c0 == '0 && out_data_o.inv_r2c1 == '0 &&
      out_data_o.inv_r2c2 == '0)
    else $error("singular result with nonzero elements");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back pressure");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

`default_nettype wire
